// ===== design/c2u_pkg.sv =====
// Shared types and functions for the CP1252 to UTF-8 transcoder.
// Holds the queue entry type, the Windows-1252 code point table and the encoder.
// Depends on nothing.
`timescale 1ns / 1ps

package c2u_pkg;

	localparam logic [7:0] WIN_FIRST = 8'd127;
	localparam logic [7:0] WIN_LAST  = 8'd159;
	localparam logic [15:0] CP_BULLET = 16'd8226;

	typedef struct packed {
		logic [1:0]      nbytes;
		logic [2:0][7:0] bytes;
	} c2u_entry_t;

	function automatic logic [15:0] win_cp(input logic [5:0] idx);
		logic [15:0] cp;
		unique case (idx)
			6'd3:    cp = 16'd8218;
			6'd4:    cp = 16'd402;
			6'd5:    cp = 16'd8222;
			6'd6:    cp = 16'd8230;
			6'd7:    cp = 16'd8224;
			6'd8:    cp = 16'd8225;
			6'd9:    cp = 16'd710;
			6'd10:   cp = 16'd8240;
			6'd11:   cp = 16'd352;
			6'd12:   cp = 16'd8249;
			6'd13:   cp = 16'd338;
			6'd18:   cp = 16'd8216;
			6'd19:   cp = 16'd8217;
			6'd20:   cp = 16'd8220;
			6'd21:   cp = 16'd8221;
			6'd23:   cp = 16'd8211;
			6'd24:   cp = 16'd8212;
			6'd25:   cp = 16'd732;
			6'd26:   cp = 16'd8482;
			6'd27:   cp = 16'd353;
			6'd28:   cp = 16'd8250;
			6'd29:   cp = 16'd339;
			6'd32:   cp = 16'd376;
			default: cp = CP_BULLET;
		endcase
		return cp;
	endfunction

	function automatic c2u_entry_t utf8_encode(input logic [15:0] cp);
		c2u_entry_t e;
		e.bytes = '0;
		if (cp < 16'h0080) begin
			e.nbytes   = 2'd1;
			e.bytes[0] = cp[7:0];
		end else if (cp < 16'h0800) begin
			e.nbytes   = 2'd2;
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
		end else begin
			e.nbytes   = 2'd3;
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

// ===== design/c2u_front.sv =====
// Front stage: accepts source bytes, holds the mode register and encodes each item.
// Depends on c2u_pkg.
`timescale 1ns / 1ps

module c2u_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	output logic                push_valid,
	input  logic                push_ready,
	output c2u_pkg::c2u_entry_t push_entry
);

	logic                passthrough_mode_q;
	logic                valid_s1;
	c2u_pkg::c2u_entry_t entry_s1;
	c2u_pkg::c2u_entry_t enc;
	logic [7:0]          win_off;
	logic [15:0]         cp;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || push_ready;
	assign win_off   = in_byte - c2u_pkg::WIN_FIRST;

	always_comb begin
		if (in_byte >= c2u_pkg::WIN_FIRST && in_byte <= c2u_pkg::WIN_LAST) begin
			cp = c2u_pkg::win_cp(win_off[5:0]);
		end else begin
			cp = {8'd0, in_byte};
		end
		if (passthrough_mode_q) begin
			enc          = '0;
			enc.nbytes   = 2'd1;
			enc.bytes[0] = in_byte;
		end else begin
			enc = c2u_pkg::utf8_encode(cp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passthrough_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			passthrough_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1 <= enc;
		end
	end

	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

endmodule

// ===== design/c2u_queue.sv =====
// Short queue of encoded items between the front and back stages.
// Depends on c2u_pkg.
`timescale 1ns / 1ps

module c2u_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  c2u_pkg::c2u_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output c2u_pkg::c2u_entry_t pop_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	c2u_pkg::c2u_entry_t mem [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;
	logic                push;
	logic                pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CW'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/c2u_back.sv =====
// Back stage: takes encoded items from the queue and emits them one byte per cycle while out_ready is high.
// Depends on c2u_pkg.
`timescale 1ns / 1ps

module c2u_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  c2u_pkg::c2u_entry_t pop_entry,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last_of_char
);

	c2u_pkg::c2u_entry_t cur_q;
	logic                cur_valid_q;
	logic [1:0]          idx_q;
	logic                last;

	assign last         = idx_q == cur_q.nbytes - 2'd1;
	assign out_valid    = cur_valid_q;
	assign out_byte     = cur_q.bytes[idx_q];
	assign last_of_char = last;
	assign pop_ready    = !cur_valid_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop_ready) begin
			cur_valid_q <= pop_valid;
			idx_q       <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q <= pop_entry;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q < cur_q.nbytes && cur_q.nbytes != 2'd0))
		else $error("byte index beyond item length");
	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> idx_q == $past(idx_q) + 2'd1)
		else $error("byte index did not advance");
	a_no_pop_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !pop_ready)
		else $error("queue popped before item finished");
`endif

endmodule

// ===== design/cp1252_to_utf8_transcoder.sv =====
// An item's first byte passes from the front register through the queue into the back
// register, and only then is it presented on the output.
// While out_ready is high the output emits one byte per cycle, and an item encoding to n
// bytes holds it until its last byte is taken, so single-byte characters flow at one item per cycle.
// The front keeps accepting while the queue has room, and the queue depth sets the slack.
// Reset clears the mode register to conversion and empties the front, queue and back.
`timescale 1ns / 1ps

module cp1252_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_char
);

	logic                push_valid;
	logic                push_ready;
	c2u_pkg::c2u_entry_t push_entry;
	logic                pop_valid;
	logic                pop_ready;
	c2u_pkg::c2u_entry_t pop_entry;

	c2u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	c2u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	c2u_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_of_char (last_of_char)
	);

endmodule

// ===== dv/cp1252_to_utf8_transcoder_tb.sv =====
// Self-checking testbench for the CP1252 to UTF-8 transcoder.
// Drives text bytes through both modes under varied backpressure and checks every UTF-8 byte.
// Depends on c2u_pkg and cp1252_to_utf8_transcoder from the design folder.
`timescale 1ns / 1ps

module cp1252_to_utf8_transcoder_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} utf8_byte_t;

	localparam logic [15:0] CP1252_HIGH [0:32] = '{
		16'd8226,
		16'd8226, 16'd8226, 16'd8218, 16'd402, 16'd8222, 16'd8230, 16'd8224, 16'd8225,
		16'd710, 16'd8240, 16'd352, 16'd8249, 16'd338, 16'd8226, 16'd8226, 16'd8226,
		16'd8226, 16'd8216, 16'd8217, 16'd8220, 16'd8221, 16'd8226, 16'd8211, 16'd8212,
		16'd732, 16'd8482, 16'd353, 16'd8250, 16'd339, 16'd8226, 16'd8226, 16'd376
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'd0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_char;

	logic [7:0] text_q [$];
	logic [7:0] staged_q [$];
	utf8_byte_t utf8_exp_q [$];
	logic       passthrough = 1'b0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_reqs = 0;
	int         hold_done = 0;
	int         hold_left = 0;
	int         mismatches = 0;
	int         cycles = 0;

	cp1252_to_utf8_transcoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_char(last_of_char)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void push_utf8(input logic [7:0] data, input logic last);
		utf8_byte_t e;
		e.data = data;
		e.last = last;
		utf8_exp_q.push_back(e);
	endfunction

	function automatic void expect_encoding(input logic [7:0] b);
		logic [15:0] cp;
		if (passthrough || b == 8'd0) begin
			push_utf8(b, 1'b1);
			return;
		end
		if (b >= c2u_pkg::WIN_FIRST && b <= c2u_pkg::WIN_LAST)
			cp = CP1252_HIGH[b - c2u_pkg::WIN_FIRST];
		else
			cp = {8'd0, b};
		if (cp < 16'h0080) begin
			push_utf8(cp[7:0], 1'b1);
		end else if (cp < 16'h0800) begin
			push_utf8({3'b110, cp[10:6]}, 1'b0);
			push_utf8({2'b10, cp[5:0]}, 1'b1);
		end else begin
			push_utf8({4'b1110, cp[15:12]}, 1'b0);
			push_utf8({2'b10, cp[11:6]}, 1'b0);
			push_utf8({2'b10, cp[5:0]}, 1'b1);
		end
	endfunction

	function automatic logic [7:0] random_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 8'd0;
		if (r < 45)
			return 8'($urandom_range(c2u_pkg::WIN_LAST, c2u_pkg::WIN_FIRST));
		return 8'($urandom_range(255, 0));
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expect_encoding(in_byte);
			if (!in_valid || in_ready) begin
				if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_byte <= text_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_reqs != hold_done) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		utf8_byte_t e;
		if (arst_n && out_valid && out_ready) begin
			if (utf8_exp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected output byte %02h last %b", out_byte, last_of_char);
			end else begin
				e = utf8_exp_q.pop_front();
				if (out_byte !== e.data || last_of_char !== e.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected byte %02h last %b, got byte %02h last %b",
							e.data, e.last, out_byte, last_of_char);
				end
			end
		end
	end

	task automatic write_mode(input logic mode);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		passthrough = mode;
	endtask

	task automatic run_phase(input logic mode, input int send_pct, input int stall_pct,
		input int n_random, input bit hold);
		write_mode(mode);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		repeat (n_random)
			staged_q.push_back(random_text_byte());
		while (staged_q.size() != 0)
			text_q.push_back(staged_q.pop_front());
		if (hold)
			hold_reqs++;
		do @(negedge clk); while (text_q.size() != 0 || in_valid || utf8_exp_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		staged_q = '{8'h00, 8'h01, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'h82, 8'h83, 8'h88,
			8'h8A, 8'h8D, 8'h98, 8'h99, 8'h9D, 8'h9F, 8'hA0, 8'hC3, 8'h55, 8'hAA, 8'hFF};
		run_phase(1'b0, 0, 0, 0, 1'b0);
		staged_q = '{8'h00, 8'h7F, 8'h80, 8'h9F, 8'hA0, 8'hFF};
		run_phase(1'b1, 0, 0, 0, 1'b0);

		run_phase(1'b0, 0, 0, 100, 1'b1);
		run_phase(1'b0, 62, 0, 80, 1'b0);
		run_phase(1'b1, 0, 62, 50, 1'b0);
		run_phase(1'b0, 0, 62, 60, 1'b0);
		run_phase(1'b0, 35, 35, 70, 1'b0);
		run_phase(1'b1, 35, 35, 20, 1'b0);
		run_phase(1'b0, 0, 0, 4, 1'b0);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
